// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHECK_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("same-cycle port rule violated");

// Next-cycle implication, disabled while reset is asserted.
`define CHECK_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("next-cycle port rule violated");

`endif

// File: rtl/pcsd_pkg.sv
// ----------------------------------------------------------------------------
// pcsd_pkg
// Shared constants, word types and command codes of the prefix code decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pcsd_pkg;

    // Table and code geometry
    localparam int TABLE_ENTRIES = 512;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int SPAN_W        = $clog2(TABLE_ENTRIES + 1);
    localparam int MAX_CODE_BITS = 32;
    localparam int LEN_W         = $clog2(MAX_CODE_BITS + 1);

    // Fixed field widths
    localparam int CMD_W     = 2;
    localparam int INDEX_W   = 9;
    localparam int SYM_W     = 8;
    localparam int CODE_W    = 32;
    localparam int ELEN_W    = 6;
    localparam int BYTE_W    = 8;
    localparam int BIT_IDX_W = $clog2(BYTE_W);
    localparam int LEN_CMP_W = (LEN_W > ELEN_W) ? LEN_W : ELEN_W;

    // Configuration registers
    localparam int LIMIT_W     = 48;
    localparam int IN_USE_W    = 10;
    localparam int CFG_DATA_W  = 48;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SYMBOL_LIMIT   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ENTRIES_IN_USE = 1'd1;

    // Command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Command field codes
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DATA    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [INDEX_W-1:0] entry_index;
        logic [SYM_W-1:0]   entry_symbol;
        logic [CODE_W-1:0]  entry_code;
        logic [ELEN_W-1:0]  entry_length;
        logic [BYTE_W-1:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             done_res;
        logic             code_error;
    } result_t;

    // Classified operation held in the queue
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_DATA,
        OP_RESTART
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [INDEX_W-1:0] index;
        logic [SYM_W-1:0]   symbol;
        logic [CODE_W-1:0]  code;
        logic [ELEN_W-1:0]  length;
        logic [BYTE_W-1:0]  data;
    } qword_t;

endpackage

`default_nettype wire

// File: rtl/prefix_code_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// prefix_code_stream_decoder_top
// Prefix code (Huffman) stream decoder against a loaded code table. Input
// words carry a command: load writes one table entry (symbol, code, length),
// data hands over one compressed byte, restart clears the decoding state
// (bit accumulator, code length, decoded count) but keeps the table and the
// registers. Each data byte is consumed LSB first; after every bit the first
// min(entries_in_use, 512) table entries are scanned in index order and the
// first entry whose length and code match the accumulated bits is emitted as
// a result word. Reaching 32 bits without a match emits an error word
// (symbol 0, code_error 1). Once symbol_limit symbols have been decoded the
// rest of the byte and all later bytes give nothing until a restart. The last
// result word of a byte carries last = 1. A front stage classifies input
// words into a four-entry command queue so that input keeps flowing while the
// back end decodes; the back end handles one command at a time. The table
// sits in a single-read-port memory read one entry per cycle, so the number
// of entries scanned per bit (scan stops at the first hit) sets the
// throughput. Results pass through a one-word pending register into the
// output register, so a stalled consumer holds the back end only when a new
// result, or the end of a byte with a result still pending, meets a full
// output register. Table entries never loaded read as undefined. Write
// configuration only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module prefix_code_stream_decoder_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Input word channel
    input  wire logic                              item_valid,
    output logic                                   item_stall,
    input  wire pcsd_pkg::item_t                   item,
    // Result word channel
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output pcsd_pkg::result_t                      result,
    // Configuration write port
    input  wire logic                              cfg_write,
    input  wire logic [pcsd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [pcsd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [pcsd_pkg::LIMIT_W-1:0]  symbol_limit_reg;
    logic [pcsd_pkg::IN_USE_W-1:0] entries_in_use_reg;
    logic [pcsd_pkg::SPAN_W-1:0]   span;

    logic                          q_full;
    logic                          q_push;
    pcsd_pkg::qword_t              q_push_word;
    logic                          q_pop;
    logic                          q_valid;
    pcsd_pkg::qword_t              q_head;

    // Configuration registers: take a write whenever the enable is high.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_limit_reg   <= '0;
            entries_in_use_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pcsd_pkg::REG_SYMBOL_LIMIT:
                begin
                    symbol_limit_reg <= pcsd_pkg::LIMIT_W'(cfg_data);
                end
                pcsd_pkg::REG_ENTRIES_IN_USE:
                begin
                    entries_in_use_reg <= pcsd_pkg::IN_USE_W'(cfg_data);
                end
                default:
                begin
                    symbol_limit_reg <= symbol_limit_reg;
                end
            endcase
        end
    end

    // Clamp the scan span to the table size.
    assign span = (32'(entries_in_use_reg) > pcsd_pkg::TABLE_ENTRIES)
                  ? pcsd_pkg::SPAN_W'(pcsd_pkg::TABLE_ENTRIES)
                  : pcsd_pkg::SPAN_W'(entries_in_use_reg);

    // Front: accept and classify input words.
    pcsd_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_word     (q_push_word)
    );

    // Queue: decouple the front from the decoding back end.
    pcsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_word  (q_push_word),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_word  (q_head)
    );

    // Back: table, decoding sequencer and result register.
    pcsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_word       (q_head),
        .q_pop        (q_pop),
        .symbol_limit (symbol_limit_reg),
        .span         (span),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// File: rtl/pcsd_front.sv
// ----------------------------------------------------------------------------
// pcsd_front
// Accepts input words, classifies the command and pushes it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsd_front (
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire pcsd_pkg::item_t item,
    input  wire logic            q_full,
    output logic                 q_push,
    output pcsd_pkg::qword_t     q_word
);

    logic known;

    always_comb
    begin
        known       = 1'b1;
        q_word.op   = pcsd_pkg::OP_LOAD;
        case (item.command)
            pcsd_pkg::CMD_LOAD:    q_word.op = pcsd_pkg::OP_LOAD;
            pcsd_pkg::CMD_DATA:    q_word.op = pcsd_pkg::OP_DATA;
            pcsd_pkg::CMD_RESTART: q_word.op = pcsd_pkg::OP_RESTART;
            default:               known     = 1'b0;
        endcase
        q_word.index  = item.entry_index;
        q_word.symbol = item.entry_symbol;
        q_word.code   = item.entry_code;
        q_word.length = item.entry_length;
        q_word.data   = item.data_byte;
    end

    // Hold the input while the queue is full; drop unknown commands.
    assign item_stall = q_full;
    assign q_push     = item_valid && !q_full && known;

endmodule

`default_nettype wire

// File: rtl/pcsd_queue.sv
// ----------------------------------------------------------------------------
// pcsd_queue
// Small first-in first-out queue of classified commands.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsd_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire pcsd_pkg::qword_t push_word,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output pcsd_pkg::qword_t      head_word
);

    pcsd_pkg::qword_t                 slot_reg [pcsd_pkg::QUEUE_DEPTH];
    logic [pcsd_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [pcsd_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [pcsd_pkg::QCNT_W-1:0]      count_reg;
    logic                             do_push;
    logic                             do_pop;

    assign full       = (count_reg == pcsd_pkg::QCNT_W'(pcsd_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_word  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/pcsd_back.sv
// ----------------------------------------------------------------------------
// pcsd_back
// Executes queued commands: table loads, restarts and bit-by-bit decoding
// of data bytes with a sequential table scan, plus the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsd_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire pcsd_pkg::qword_t              q_word,
    output logic                               q_pop,
    input  wire logic [pcsd_pkg::LIMIT_W-1:0]  symbol_limit,
    input  wire logic [pcsd_pkg::SPAN_W-1:0]   span,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output pcsd_pkg::result_t                  result
);

    localparam int ACC_W = pcsd_pkg::MAX_CODE_BITS;

    typedef struct packed {
        logic [pcsd_pkg::SYM_W-1:0]  symbol;
        logic [pcsd_pkg::CODE_W-1:0] code;
        logic [pcsd_pkg::ELEN_W-1:0] length;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BIT,
        S_SCAN,
        S_EMIT,
        S_STEP,
        S_FLUSH
    } state_t;

    entry_t table_mem [pcsd_pkg::TABLE_ENTRIES];

    state_t                             state_reg,    state_next;
    logic [pcsd_pkg::BYTE_W-1:0]        byte_reg,     byte_next;
    logic [pcsd_pkg::BIT_IDX_W-1:0]     bit_idx_reg,  bit_idx_next;
    logic [ACC_W-1:0]                   acc_reg,      acc_next;
    logic [ACC_W-1:0]                   mask_reg,     mask_next;
    logic [pcsd_pkg::LEN_W-1:0]         acc_len_reg,  acc_len_next;
    logic [pcsd_pkg::LIMIT_W-1:0]       count_reg,    count_next;
    logic [pcsd_pkg::SPAN_W-1:0]        idx_reg,      idx_next;
    logic                               rd_vld_reg,   rd_vld_next;
    logic [pcsd_pkg::SYM_W-1:0]         res_sym_reg,  res_sym_next;
    logic                               res_err_reg,  res_err_next;
    logic                               pend_vld_reg, pend_vld_next;
    pcsd_pkg::result_t                  pend_reg,     pend_next;
    logic                               out_vld_reg,  out_vld_next;
    pcsd_pkg::result_t                  out_reg,      out_next;

    entry_t                             rd_data_reg;
    logic                               rd_en;
    logic                               wr_en;
    logic [pcsd_pkg::IDX_W-1:0]         wr_addr;
    logic                               hit;
    logic                               out_free;
    logic                               done_now;
    logic [ACC_W-1:0]                   grown_mask;
    logic [ACC_W-1:0]                   code_ext;
    pcsd_pkg::result_t                  fresh;

    // Table memory: one write port for loads, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= '{symbol: q_word.symbol, code: q_word.code,
                                    length: q_word.length};
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[idx_reg[pcsd_pkg::IDX_W-1:0]];
        end
    end

    assign wr_addr    = pcsd_pkg::IDX_W'(q_word.index);
    assign out_free   = !out_vld_reg || !result_stall;
    assign done_now   = (count_reg >= symbol_limit);
    assign grown_mask = {mask_reg[ACC_W-2:0], 1'b1};
    assign code_ext   = ACC_W'(rd_data_reg.code);
    assign rd_en      = (state_reg == S_SCAN) && (idx_reg < span);

    // Entry matches when lengths agree and the masked code equals the bits.
    assign hit = rd_vld_reg
                 && (pcsd_pkg::LEN_CMP_W'(rd_data_reg.length)
                     == pcsd_pkg::LEN_CMP_W'(acc_len_reg))
                 && (((code_ext ^ acc_reg) & mask_reg) == '0);

    always_comb
    begin
        fresh.symbol     = res_sym_reg;
        fresh.last       = 1'b0;
        fresh.done_res   = done_now;
        fresh.code_error = res_err_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        byte_next     = byte_reg;
        bit_idx_next  = bit_idx_reg;
        acc_next      = acc_reg;
        mask_next     = mask_reg;
        acc_len_next  = acc_len_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        rd_vld_next   = 1'b0;
        res_sym_next  = res_sym_reg;
        res_err_next  = res_err_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        out_vld_next  = out_vld_reg && result_stall;
        out_next      = out_reg;
        q_pop         = 1'b0;
        wr_en         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_word.op)
                        pcsd_pkg::OP_LOAD:
                        begin
                            wr_en = (32'(q_word.index) < pcsd_pkg::TABLE_ENTRIES);
                        end
                        pcsd_pkg::OP_RESTART:
                        begin
                            acc_next     = '0;
                            mask_next    = '0;
                            acc_len_next = '0;
                            count_next   = '0;
                        end
                        pcsd_pkg::OP_DATA:
                        begin
                            byte_next    = q_word.data;
                            bit_idx_next = '0;
                            state_next   = S_BIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_BIT:
            begin
                if (done_now)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    // Append the next byte bit at the current code length.
                    mask_next    = grown_mask;
                    acc_next     = acc_reg | ((grown_mask & ~mask_reg)
                                   & {ACC_W{byte_reg[bit_idx_reg]}});
                    acc_len_next = acc_len_reg + 1'b1;
                    idx_next     = '0;
                    state_next   = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (rd_en)
                begin
                    idx_next    = idx_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end
                if (hit)
                begin
                    count_next   = count_reg + 1'b1;
                    res_sym_next = rd_data_reg.symbol;
                    res_err_next = 1'b0;
                    acc_next     = '0;
                    mask_next    = '0;
                    acc_len_next = '0;
                    state_next   = S_EMIT;
                end
                else if (!rd_vld_reg && !rd_en)
                begin
                    if (acc_len_reg == pcsd_pkg::LEN_W'(pcsd_pkg::MAX_CODE_BITS))
                    begin
                        res_sym_next = '0;
                        res_err_next = 1'b1;
                        acc_next     = '0;
                        mask_next    = '0;
                        acc_len_next = '0;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_STEP;
                    end
                end
            end

            S_EMIT:
            begin
                // Hold one result back until its last flag is known.
                if (!pend_vld_reg)
                begin
                    pend_next     = fresh;
                    pend_vld_next = 1'b1;
                    state_next    = S_STEP;
                end
                else if (out_free)
                begin
                    out_next     = pend_reg;
                    out_vld_next = 1'b1;
                    pend_next    = fresh;
                    state_next   = S_STEP;
                end
            end

            S_STEP:
            begin
                if (bit_idx_reg == pcsd_pkg::BIT_IDX_W'(pcsd_pkg::BYTE_W - 1))
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    bit_idx_next = bit_idx_reg + 1'b1;
                    state_next   = S_BIT;
                end
            end

            S_FLUSH:
            begin
                if (!pend_vld_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_next      = pend_reg;
                    out_next.last = 1'b1;
                    out_vld_next  = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            bit_idx_reg  <= '0;
            acc_reg      <= '0;
            mask_reg     <= '0;
            acc_len_reg  <= '0;
            count_reg    <= '0;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bit_idx_reg  <= bit_idx_next;
            acc_reg      <= acc_next;
            mask_reg     <= mask_next;
            acc_len_reg  <= acc_len_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            rd_vld_reg   <= rd_vld_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg    <= byte_next;
        res_sym_reg <= res_sym_next;
        res_err_reg <= res_err_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

// File: rtl/pcsd_checker.sv
// ----------------------------------------------------------------------------
// pcsd_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pcsd_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              result_valid,
    input  wire logic              result_stall,
    input  wire pcsd_pkg::result_t result
);

    // Hold a stalled result word.
    `CHECK_NEXT(a_valid_held, clk, rst_n, result_valid && result_stall, result_valid)
    `CHECK_NEXT(a_word_held, clk, rst_n, result_valid && result_stall, $stable(result))

    // An error word never carries a symbol.
    `CHECK_NOW(a_error_symbol, clk, rst_n, result_valid && result.code_error,
        result.symbol == '0)

    // Reaching the limit ends the byte.
    `CHECK_NOW(a_done_last, clk, rst_n, result_valid && result.done_res, result.last)

endmodule

bind prefix_code_stream_decoder_top pcsd_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

// File: sim/tb_prefix_code_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// tb_prefix_code_stream_decoder_top
// Self-checking bench for the prefix code stream decoder. The low table slots
// are filled first, and every search span stays inside the filled slots or
// stops at a hit, so no search ever reads an unloaded slot. A directed part
// then covers short, shadowed, full-width and overlong codes, the symbol
// limit, restart and the search span extremes. A random part loads random
// complete prefix codes and feeds their bit streams, mixed with noise,
// corrupted bytes, restarts, stray loads and unused commands. An in-bench
// decoder predicts every result word, and a checker compares each accepted
// word field by field under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_prefix_code_stream_decoder_top;

    import pcsd_pkg::*;

    localparam logic [CMD_W-1:0]   CMD_UNUSED     = 2'd3;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX      = 48'hFFFF_FFFF_FFFF;
    localparam int unsigned        WATCHDOG_LIMIT = 200000;
    // Covers the largest random code (30 slots) plus the widest span margin
    localparam int                 FILL_SLOTS     = 40;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports
    // ------------------------------------------------------------------------
    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_stall;
    item_t                  item         = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result;
    logic                   cfg_write    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    always #1 clk = ~clk;

    prefix_code_stream_decoder_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Decoder state mirrored by the bench
    // ------------------------------------------------------------------------
    logic [SYM_W-1:0]    slot_symbol [TABLE_ENTRIES];
    logic [CODE_W-1:0]   slot_code   [TABLE_ENTRIES];
    logic [ELEN_W-1:0]   slot_length [TABLE_ENTRIES];
    logic [63:0]         shift_bits    = '0;
    int unsigned         shift_count   = 0;
    logic [LIMIT_W-1:0]  decoded_total = '0;
    logic [LIMIT_W-1:0]  symbol_budget = '0;
    logic [IN_USE_W-1:0] search_span   = '0;

    // Symbols still owed by the block, oldest first
    result_t     pending_symbols [$];
    result_t     expected_word;
    int unsigned fail_count   = 0;
    int unsigned quiet_cycles = 0;

    // Idle mix of the current phase, in percent per cycle
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;

    // Current random prefix code, first code bit in bit zero
    logic [CODE_W-1:0] leaf_code [$];
    int unsigned       leaf_len  [$];
    bit                code_stream [$];

    // ------------------------------------------------------------------------
    // Predict the result words of one accepted input word
    // ------------------------------------------------------------------------
    function automatic void decode_word(input item_t w);
        result_t     batch [$];
        result_t     r;
        int unsigned span;
        bit          hit;
        case (w.command)
            CMD_LOAD:
            begin
                slot_symbol[w.entry_index] = w.entry_symbol;
                slot_code[w.entry_index]   = w.entry_code;
                slot_length[w.entry_index] = w.entry_length;
            end
            CMD_RESTART:
            begin
                shift_bits    = '0;
                shift_count   = 0;
                decoded_total = '0;
            end
            CMD_DATA:
            begin
                span = (search_span > TABLE_ENTRIES) ? TABLE_ENTRIES : search_span;
                for (int b = 0; b < BYTE_W; b++)
                begin
                    // Once the limit is hit, drop the rest of the byte
                    if (decoded_total >= symbol_budget)
                        break;
                    if (shift_count >= MAX_CODE_BITS)
                    begin
                        shift_bits  = '0;
                        shift_count = 0;
                    end
                    if (w.data_byte[b])
                        shift_bits[shift_count] = 1'b1;
                    shift_count++;
                    hit = 1'b0;
                    for (int i = 0; i < span; i++)
                    begin
                        if (slot_length[i] != 0 && slot_length[i] <= MAX_CODE_BITS &&
                            slot_length[i] == shift_count &&
                            (64'(slot_code[i]) & ((64'd1 << slot_length[i]) - 64'd1))
                                == shift_bits)
                        begin
                            decoded_total = decoded_total + 1'b1;
                            r.symbol      = slot_symbol[i];
                            r.last        = 1'b0;
                            r.done_res    = (decoded_total >= symbol_budget);
                            r.code_error  = 1'b0;
                            batch.push_back(r);
                            hit = 1'b1;
                            break;
                        end
                    end
                    if (hit)
                    begin
                        shift_bits  = '0;
                        shift_count = 0;
                    end
                    else if (shift_count >= MAX_CODE_BITS)
                    begin
                        // Overlong code: error word, count unchanged
                        r.symbol     = '0;
                        r.last       = 1'b0;
                        r.done_res   = (decoded_total >= symbol_budget);
                        r.code_error = 1'b1;
                        batch.push_back(r);
                        shift_bits  = '0;
                        shift_count = 0;
                    end
                end
                if (batch.size() > 0)
                begin
                    r = batch.pop_back();
                    r.last = 1'b1;
                    batch.push_back(r);
                end
                foreach (batch[k])
                    pending_symbols.push_back(batch[k]);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Word sender: optional idle gap, then hold the word until accepted
    // ------------------------------------------------------------------------
    task automatic send_word(input item_t w);
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        decode_word(w);
    endtask

    // Fill every field at random so ignored fields toggle too
    function automatic item_t random_word(input logic [CMD_W-1:0] cmd);
        item_t w;
        w.command      = cmd;
        w.entry_index  = INDEX_W'($urandom());
        w.entry_symbol = SYM_W'($urandom());
        w.entry_code   = $urandom();
        w.entry_length = ELEN_W'($urandom());
        w.data_byte    = BYTE_W'($urandom());
        return w;
    endfunction

    task automatic send_load(input int unsigned idx, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] code, input int unsigned len);
        item_t w;
        w              = random_word(CMD_LOAD);
        w.entry_index  = INDEX_W'(idx);
        w.entry_symbol = sym;
        w.entry_code   = code;
        w.entry_length = ELEN_W'(len);
        send_word(w);
    endtask

    task automatic send_data(input logic [BYTE_W-1:0] data);
        item_t w;
        w           = random_word(CMD_DATA);
        w.data_byte = data;
        send_word(w);
    endtask

    task automatic send_restart();
        send_word(random_word(CMD_RESTART));
    endtask

    // ------------------------------------------------------------------------
    // Drop valid, drain every owed symbol, then give bytes that decode to
    // nothing time to leave the command queue before touching registers.
    // ------------------------------------------------------------------------
    task automatic wait_idle();
        int unsigned span;
        item_valid <= 1'b0;
        while (pending_symbols.size() != 0)
            @(posedge clk);
        span = (search_span > TABLE_ENTRIES) ? TABLE_ENTRIES : search_span;
        repeat ((QUEUE_DEPTH + 3) * (8 * (span + 4) + 3) + 32)
            @(posedge clk);
    endtask

    // Write both registers on back-to-back cycles; block must be idle
    task automatic program_regs(input logic [LIMIT_W-1:0] budget,
                                input logic [IN_USE_W-1:0] in_use);
        cfg_write <= 1'b1;
        cfg_index <= REG_SYMBOL_LIMIT;
        cfg_data  <= budget;
        @(posedge clk);
        cfg_index <= REG_ENTRIES_IN_USE;
        cfg_data  <= CFG_DATA_W'(in_use);
        @(posedge clk);
        cfg_write     <= 1'b0;
        symbol_budget  = budget;
        search_span    = in_use;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Load the low slots with entries that never match
    task automatic test_fill_table();
        for (int i = 0; i < FILL_SLOTS; i++)
            send_load(i, SYM_W'($urandom()), $urandom(),
                      ($urandom_range(1) == 0) ? 0 : $urandom_range(63, MAX_CODE_BITS + 1));
    endtask

    // Three-symbol complete code plus a shadowed duplicate
    task automatic test_short_codes();
        wait_idle();
        program_regs(LIMIT_MAX, 4);
        send_load(0, 8'h00, 32'hFFFF_FFFE, 1);  // "0"; high bits must be ignored
        send_load(1, 8'hFF, 32'h0000_0001, 2);  // "10" in stream order
        send_load(2, 8'h3C, 32'hFFFF_FFFF, 2);  // "11"
        send_load(3, 8'h77, 32'h0000_0003, 2);  // same code, loses to slot 2
        send_data(8'h00);                       // eight symbols from one byte
        send_data(8'hFF);
        send_data(8'hAA);                       // leaves one bit pending
        send_data(8'h01);                       // completes the code across bytes
        send_word(random_word(CMD_UNUSED));
        send_data(8'h80);
        send_restart();                         // drop the pending bit
        send_data(8'h02);
    endtask

    // Full-width match, oversized lengths, and an overlong unmatched code
    task automatic test_long_codes();
        send_restart();
        send_load(0, 8'h81, 32'hFFFF_FFFF, MAX_CODE_BITS);
        send_load(2, 8'hFF, 32'h0000_0000, 63);
        send_load(3, 8'h18, 32'h0000_0000, MAX_CODE_BITS);
        repeat (4)
            send_data(8'hFF);
        send_data(8'hF0);
        repeat (3)
            send_data(8'hFF);
    endtask

    // Empty span, zero limit, small limit with restart, saturated span
    task automatic test_limits_and_span();
        wait_idle();
        program_regs(3, 0);
        repeat (4)
            send_data(8'h00);                   // nothing searched: one error word
        wait_idle();
        program_regs(0, 4);
        send_data(8'hFF);                       // limit of zero: nothing comes out
        wait_idle();
        program_regs(3, 1023);
        send_restart();
        send_load(0, 8'h5A, 32'h0000_0000, 1);  // every bit hits slot 0
        send_data(8'h00);                       // three symbols, third flagged done
        send_data(8'h00);                       // ignored until restart
        send_restart();
        send_data(8'h00);
    endtask

    // Random complete prefix code, placed among junk slots, then its stream
    task automatic run_code_stream(input int unsigned n_bytes);
        int unsigned        leaves, slots, in_use, sent, pick, j, tmp, r;
        int unsigned        slot_order [$];
        logic [CODE_W-1:0]  noise;
        logic [LIMIT_W-1:0] budget;
        logic [BYTE_W-1:0]  data;

        // Grow the code tree by splitting leaves; favor the newest leaf
        // half the time so that some codes run deep.
        leaves = $urandom_range(24, 2);
        leaf_code.delete();
        leaf_len.delete();
        leaf_code.push_back('0);
        leaf_len.push_back(0);
        while (leaf_len.size() < leaves)
        begin
            j = ($urandom_range(1) == 1) ? leaf_len.size() - 1
                                         : $urandom_range(leaf_len.size() - 1, 0);
            leaf_code.push_back(leaf_code[j] | (32'd1 << leaf_len[j]));
            leaf_len.push_back(leaf_len[j] + 1);
            leaf_len[j] = leaf_len[j] + 1;
        end

        // Shuffle leaves and junk over the low slots
        slots = leaves + $urandom_range(6, 0);
        slot_order.delete();
        for (int k = 0; k < slots; k++)
            slot_order.push_back(k);
        for (int k = slots - 1; k > 0; k--)
        begin
            j             = $urandom_range(k, 0);
            tmp           = slot_order[k];
            slot_order[k] = slot_order[j];
            slot_order[j] = tmp;
        end

        pick = $urandom_range(99);
        if (pick < 20)
            in_use = $urandom_range(slots, 1);      // cut the code: expect errors
        else if (pick < 40)
            in_use = slots + $urandom_range(8, 0);
        else
            in_use = slots;
        budget = ($urandom_range(99) < 70) ? LIMIT_MAX : LIMIT_W'($urandom_range(40, 1));

        wait_idle();
        program_regs(budget, IN_USE_W'(in_use));
        code_stream.delete();

        for (int k = 0; k < slots; k++)
        begin
            noise = $urandom();
            if (k < leaves)
                send_load(slot_order[k], SYM_W'($urandom()),
                          (noise & ~((32'd1 << leaf_len[k]) - 32'd1)) | leaf_code[k],
                          leaf_len[k]);
            else
            begin
                pick = $urandom_range(2);
                send_load(slot_order[k], SYM_W'($urandom()), noise,
                          (pick == 0) ? 0 :
                          (pick == 1) ? $urandom_range(63, MAX_CODE_BITS + 1) :
                                        $urandom_range(12, 1));
            end
        end

        sent = 0;
        while (sent < n_bytes)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
            begin
                send_restart();
                code_stream.delete();               // realign with the decoder
            end
            else if (pick < 8)
                send_word(random_word(CMD_LOAD));
            else if (pick < 10)
                send_word(random_word(CMD_UNUSED));
            else
            begin
                if (pick < 88)
                begin
                    while (code_stream.size() < BYTE_W)
                    begin
                        r = $urandom_range(leaf_len.size() - 1, 0);
                        for (int b = 0; b < leaf_len[r]; b++)
                            code_stream.push_back(leaf_code[r][b]);
                    end
                    for (int b = 0; b < BYTE_W; b++)
                        data[b] = code_stream.pop_front();
                    // Flip one bit now and then to break the stream
                    if (pick >= 82)
                    begin
                        j       = $urandom_range(BYTE_W - 1, 0);
                        data[j] = ~data[j];
                    end
                end
                else
                    data = BYTE_W'($urandom());
                send_data(data);
                sent++;
            end
        end
    endtask

    // Four idle mixes, two random codes each
    task automatic test_random_streams();
        int unsigned send_mix  [4] = '{0, 74, 0, 13};
        int unsigned stall_mix [4] = '{0, 0, 74, 13};
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = send_mix[p];
            stall_pct     = stall_mix[p];
            for (int c = 0; c < 2; c++)
                run_code_stream(22);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall, and compare each accepted word with the
    // oldest owed symbol.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_symbols.size() == 0)
            begin
                $error("result word with nothing owed: symbol %0h code_error %0b",
                       result.symbol, result.code_error);
                fail_count++;
            end
            else
            begin
                expected_word = pending_symbols.pop_front();
                if (result.symbol !== expected_word.symbol)
                begin
                    $error("symbol: expected %0h, got %0h",
                           expected_word.symbol, result.symbol);
                    fail_count++;
                end
                if (result.last !== expected_word.last)
                begin
                    $error("last: expected %0b, got %0b", expected_word.last, result.last);
                    fail_count++;
                end
                if (result.done_res !== expected_word.done_res)
                begin
                    $error("done_res: expected %0b, got %0b",
                           expected_word.done_res, result.done_res);
                    fail_count++;
                end
                if (result.code_error !== expected_word.code_error)
                begin
                    $error("code_error: expected %0b, got %0b",
                           expected_word.code_error, result.code_error);
                    fail_count++;
                end
            end
        end
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: end the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_table();
        test_short_codes();
        test_long_codes();
        test_limits_and_span();
        test_random_streams();

        wait_idle();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
